[rtl/csbf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csbf_pkg: shared types and constants for the comment-stripping byte filter
// Character codes, scan mode codes and the output queue entry type.
// ----------------------------------------------------------------------------
package csbf_pkg;

  // character codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;

  // scan mode codes
  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_STRING = 3'd1;
  localparam logic [2:0] MODE_CHAR   = 3'd2;
  localparam logic [2:0] MODE_SLASH  = 3'd3;
  localparam logic [2:0] MODE_LINE   = 3'd4;
  localparam logic [2:0] MODE_BLOCK  = 3'd5;

  // output queue depth and its count width
  localparam int unsigned QDEPTH = 3;
  localparam int unsigned QCW    = 2;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_entry_t;

endpackage

[rtl/comment_stripping_byte_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comment_stripping_byte_filter: streaming C comment stripper
// Removes comments, maps newline/semicolon outside quotes, drops blanks.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one raw text byte per transfer (in_tdata[7:0]).
//   out_* : zero, one or two result bytes per input byte; out_tlast marks
//           the final result byte caused by that input byte. Input bytes that
//           yield nothing (comment text, blanks, a slash awaiting its
//           partner) produce no transfer at all.
//   Results are registered in the result queue, behind any results already queued.
//   Throughput: one input byte per cycle. The scan step is a single pass of
//   short logic from the input port into a three-entry result queue; an
//   input is taken whenever the queue has room for two results after this
//   cycle's output transfer. A lone slash followed by an emitted byte yields
//   two results.
//   Reset (rst_n low, synchronous): scan mode returns to normal, all escape
//   and star flags clear, the result queue empties.
//   Stall: while out_tready is low the head result holds; further input
//   is still accepted while the queue holds at most one result.
// ----------------------------------------------------------------------------
module comment_stripping_byte_filter
  import csbf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  // result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // run_last
);

  // scan state
  logic [2:0] mode_r, mode_nxt;
  logic       sesc_r, sesc_nxt;   // string escape pending
  logic       cesc_r, cesc_nxt;   // char escape pending
  logic       lesc_r, lesc_nxt;   // line comment escape pending
  logic       star_r, star_nxt;   // star seen in block comment

  // result queue, entry 0 is the head
  res_entry_t       q_r   [QDEPTH];
  res_entry_t       q_nxt [QDEPTH];
  logic [QCW-1:0]   cnt_r, cnt_nxt;

  logic       in_xfer;
  logic       out_xfer;
  logic [7:0] c;

  // step results: a leading slash (a) and the byte's own result (b)
  logic       a_v;
  logic       b_v;
  logic [7:0] b_byte;
  logic       nrm;        // byte takes normal-mode handling
  logic [7:0] mapped;
  logic [1:0] n_res;
  res_entry_t r0, r1;
  logic [QCW-1:0] base;

  assign c        = in_tdata;
  assign out_xfer = out_tvalid & out_tready;
  // room for two results once this cycle's head leaves
  assign in_tready = (cnt_r <= QCW'(1)) || ((cnt_r == QCW'(2)) && out_xfer);
  assign in_xfer   = in_tvalid & in_tready;

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = q_r[0].data;
  assign out_tlast  = q_r[0].last;

  always_comb begin
    mapped = c;
    if (c == CH_NL) begin
      mapped = CH_SPACE;
    end else if (c == CH_SEMI) begin
      mapped = CH_NL;
    end
  end

  // scan step
  always_comb begin
    mode_nxt = mode_r;
    sesc_nxt = sesc_r;
    cesc_nxt = cesc_r;
    lesc_nxt = lesc_r;
    star_nxt = star_r;
    a_v      = 1'b0;
    b_v      = 1'b0;
    b_byte   = c;
    nrm      = 1'b0;
    case (mode_r)
      MODE_STRING: begin
        b_v = 1'b1;
        if (c == CH_DQ && !sesc_r) begin
          mode_nxt = MODE_NORMAL;
        end
        sesc_nxt = (c == CH_BSL) && !sesc_r;
      end
      MODE_CHAR: begin
        b_v = 1'b1;
        if (c == CH_SQ && !cesc_r) begin
          mode_nxt = MODE_NORMAL;
        end
        cesc_nxt = (c == CH_BSL) && !cesc_r;
      end
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          mode_nxt = MODE_LINE;
        end else if (c == CH_STAR) begin
          mode_nxt = MODE_BLOCK;
        end else begin
          a_v = 1'b1;
          nrm = 1'b1;
        end
      end
      MODE_LINE: begin
        // the closing newline is not emitted
        if (c == CH_NL && !lesc_r) begin
          mode_nxt = MODE_NORMAL;
        end
        lesc_nxt = (c == CH_BSL) && !lesc_r;
      end
      MODE_BLOCK: begin
        if (c == CH_SLASH && star_r) begin
          mode_nxt = MODE_NORMAL;
        end
        star_nxt = (c == CH_STAR);
      end
      default: begin
        nrm = 1'b1;
      end
    endcase

    if (nrm) begin
      mode_nxt = MODE_NORMAL;
      if (c == CH_DQ) begin
        mode_nxt = MODE_STRING;
        b_v      = 1'b1;
      end else if (c == CH_SQ) begin
        mode_nxt = MODE_CHAR;
        b_v      = 1'b1;
      end else if (c == CH_SLASH) begin
        mode_nxt = MODE_SLASH;
      end else begin
        b_v    = 1'b1;
        b_byte = mapped;
      end
    end

    // blanks never leave the block
    if (b_byte == CH_SPACE || b_byte == CH_TAB) begin
      b_v = 1'b0;
    end
  end

  // pack results into order
  always_comb begin
    n_res   = {1'b0, a_v} + {1'b0, b_v};
    r0.data = a_v ? CH_SLASH : b_byte;
    r0.last = !(a_v && b_v);
    r1.data = b_byte;
    r1.last = 1'b1;
  end

  // queue update: pop shifts down, push appends behind what remains
  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    base = cnt_r;
    if (out_xfer) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
      base = cnt_r - QCW'(1);
    end
    cnt_nxt = base;
    if (in_xfer) begin
      for (int i = 0; i < QDEPTH; i++) begin
        if ((n_res != 2'd0) && (base == QCW'(i))) begin
          q_nxt[i] = r0;
        end
        if ((n_res == 2'd2) && ((base + QCW'(1)) == QCW'(i))) begin
          q_nxt[i] = r1;
        end
      end
      cnt_nxt = base + QCW'(n_res);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      sesc_r <= 1'b0;
      cesc_r <= 1'b0;
      lesc_r <= 1'b0;
      star_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (in_xfer) begin
        mode_r <= mode_nxt;
        sesc_r <= sesc_nxt;
        cesc_r <= cesc_nxt;
        lesc_r <= lesc_nxt;
        star_r <= star_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

[rtl/csbf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csbf_checker: port-level checks for the comment-stripping byte filter
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module csbf_checker
  import csbf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // nothing pending straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // blanks are always dropped
  a_no_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata != CH_SPACE) && (out_tdata != CH_TAB))
    else $error("blank byte emitted");

  // the second byte of a pair follows straight behind the first
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("second result of a pair missing");

  // a non-final result is always the slash that failed to open a comment
  a_pair_head_slash: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata == CH_SLASH)
    else $error("unexpected leading byte of a pair");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind comment_stripping_byte_filter csbf_checker u_csbf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the comment-stripping byte filter
// Feeds a directed table of corner bytes, then C-like text built from random
// strings, char literals, comments, lone slashes and statements. A scan model
// in the bench predicts every result byte and its last flag; the monitor
// compares each result transfer with the oldest prediction. Sender gaps and
// receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;
  import csbf_pkg::*;

  localparam int BY_MODEL     = -1;    // table row checked by the scan model
  localparam int PHASE_ITEMS  = 250;   // minimum random bytes per phase
  localparam int STALL_LIMIT  = 2000;  // cycles without any transfer
  localparam int DRAIN_CYCLES = 8;     // extra wait after the results drain

  // bytes the random text leans on
  localparam logic [7:0] KEY_BYTES [9] = '{CH_NL, CH_TAB, CH_SPACE, CH_SEMI, CH_BSL,
                                           CH_SLASH, CH_STAR, CH_DQ, CH_SQ};

  typedef struct {
    logic [7:0] in_byte;
    int         n_res;     // BY_MODEL, or the number of results typed in
    logic [7:0] res0;
    logic [7:0] res1;
  } dir_row_t;

  // directed table: blanks, mapping, lone slash, comments, quotes, escapes
  localparam int DIR_ROWS = 27;
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{8'h00,    1,        8'h00,    8'h00},   // lowest byte passes
    '{8'hFF,    1,        8'hFF,    8'h00},   // highest byte passes
    '{CH_SPACE, 0,        8'h00,    8'h00},   // blank dropped
    '{CH_TAB,   0,        8'h00,    8'h00},   // tab dropped
    '{CH_NL,    0,        8'h00,    8'h00},   // newline -> space -> dropped
    '{CH_SEMI,  1,        CH_NL,    8'h00},   // semicolon -> newline
    '{CH_SLASH, 0,        8'h00,    8'h00},   // slash held back
    '{8'h61,    2,        CH_SLASH, 8'h61},   // lone slash emitted, then 'a'
    '{CH_SLASH, 0,        8'h00,    8'h00},
    '{CH_SPACE, 1,        CH_SLASH, 8'h00},   // slash kept, blank after it dropped
    '{CH_SLASH, BY_MODEL, 8'h00,    8'h00},   // line comment
    '{CH_SLASH, BY_MODEL, 8'h00,    8'h00},
    '{CH_BSL,   BY_MODEL, 8'h00,    8'h00},
    '{CH_NL,    BY_MODEL, 8'h00,    8'h00},   // escaped newline continues it
    '{CH_NL,    BY_MODEL, 8'h00,    8'h00},   // plain newline ends it
    '{CH_SLASH, BY_MODEL, 8'h00,    8'h00},   // block comment
    '{CH_STAR,  BY_MODEL, 8'h00,    8'h00},
    '{CH_STAR,  BY_MODEL, 8'h00,    8'h00},
    '{CH_SLASH, BY_MODEL, 8'h00,    8'h00},   // star-slash closes
    '{CH_DQ,    BY_MODEL, 8'h00,    8'h00},   // string
    '{CH_BSL,   BY_MODEL, 8'h00,    8'h00},
    '{CH_DQ,    BY_MODEL, 8'h00,    8'h00},   // escaped quote stays inside
    '{CH_SEMI,  BY_MODEL, 8'h00,    8'h00},   // no mapping inside quotes
    '{CH_SPACE, BY_MODEL, 8'h00,    8'h00},   // still dropped inside quotes
    '{CH_DQ,    BY_MODEL, 8'h00,    8'h00},   // closes the string
    '{CH_SQ,    BY_MODEL, 8'h00,    8'h00},   // char literal opens
    '{CH_SQ,    BY_MODEL, 8'h00,    8'h00}    // and closes
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  // scan model state
  logic [2:0] scan_st = MODE_NORMAL;
  logic       str_esc = 1'b0;
  logic       chr_esc = 1'b0;
  logic       line_esc = 1'b0;
  logic       star_seen = 1'b0;

  logic [7:0] emitted_q [$];   // bytes the current input gives
  res_entry_t pending_res_q [$];
  res_entry_t head_res;
  logic [7:0] text_q [$];      // random text waiting to be sent

  int src_idle = 0;
  int sink_stall = 0;
  int err_cnt = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;
  bit held_off = 1'b0;         // sender already paused for a full drain

  comment_stripping_byte_filter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- scan model
  function automatic void emit_byte(logic [7:0] c);
    if (c != CH_SPACE && c != CH_TAB) emitted_q = {emitted_q, c};
  endfunction

  function automatic logic [7:0] map_outside(logic [7:0] c);
    if (c == CH_NL) return CH_SPACE;
    if (c == CH_SEMI) return CH_NL;
    return c;
  endfunction

  function automatic void scan_normal(logic [7:0] c);
    scan_st = MODE_NORMAL;
    if (c == CH_DQ) begin
      scan_st = MODE_STRING;
      emit_byte(c);
    end else if (c == CH_SQ) begin
      scan_st = MODE_CHAR;
      emit_byte(c);
    end else if (c == CH_SLASH) begin
      scan_st = MODE_SLASH;
    end else begin
      emit_byte(map_outside(c));
    end
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    emitted_q.delete();
    case (scan_st)
      MODE_STRING: begin
        emit_byte(c);
        if (c == CH_DQ && !str_esc) scan_st = MODE_NORMAL;
        str_esc = (c == CH_BSL) && !str_esc;
      end
      MODE_CHAR: begin
        emit_byte(c);
        if (c == CH_SQ && !chr_esc) scan_st = MODE_NORMAL;
        chr_esc = (c == CH_BSL) && !chr_esc;
      end
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          scan_st = MODE_LINE;
        end else if (c == CH_STAR) begin
          scan_st = MODE_BLOCK;
        end else begin
          emit_byte(CH_SLASH);
          scan_normal(c);
        end
      end
      MODE_LINE: begin
        // the closing newline is not emitted, so it never shows
        if (c == CH_NL && !line_esc) scan_st = MODE_NORMAL;
        line_esc = (c == CH_BSL) && !line_esc;
      end
      MODE_BLOCK: begin
        if (c == CH_SLASH && star_seen) scan_st = MODE_NORMAL;
        star_seen = (c == CH_STAR);
      end
      default: scan_normal(c);
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus
  // Entered and left at a falling edge. Expected results are queued at the
  // edge where the input transfer happens.
  task automatic send_byte(input logic [7:0] b, input int n_res,
                           input logic [7:0] res0, input logic [7:0] res1);
    res_entry_t exp_res;
    while ($urandom_range(0, 99) < src_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scan_byte(b);
    if (n_res != BY_MODEL) begin
      emitted_q.delete();
      if (n_res >= 1) emitted_q = {emitted_q, res0};
      if (n_res >= 2) emitted_q = {emitted_q, res1};
    end
    foreach (emitted_q[k]) begin
      exp_res.data  = emitted_q[k];
      exp_res.last  = (k == emitted_q.size() - 1);
      pending_res_q = {pending_res_q, exp_res};
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'($urandom_range(0, 255));
      3, 4, 5: return 8'($urandom_range(8'h21, 8'h7E));
      default: return KEY_BYTES[$urandom_range(0, 8)];
    endcase
  endfunction

  function automatic void add_text(logic [7:0] b);
    text_q = {text_q, b};
  endfunction

  // one random construct of C-like text; content is random, so some
  // constructs end early or run on into the next one
  task automatic add_construct();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1: begin
        repeat ($urandom_range(1, 6)) add_text(rand_byte());
      end
      2: begin
        add_text(CH_DQ);
        repeat ($urandom_range(0, 6)) begin
          b = rand_byte();
          if (b == CH_DQ) add_text(CH_BSL);
          add_text(b);
        end
        add_text(CH_DQ);
      end
      3: begin
        add_text(CH_SQ);
        if ($urandom_range(0, 2) == 0) add_text(CH_BSL);
        add_text(rand_byte());
        add_text(CH_SQ);
      end
      4: begin
        add_text(CH_SLASH);
        add_text(CH_SLASH);
        repeat ($urandom_range(0, 5)) add_text(rand_byte());
        if ($urandom_range(0, 2) == 0) begin
          add_text(CH_BSL);
          add_text(CH_NL);
          repeat ($urandom_range(0, 3)) add_text(rand_byte());
        end
        add_text(CH_NL);
      end
      5: begin
        add_text(CH_SLASH);
        add_text(CH_STAR);
        repeat ($urandom_range(0, 6))
          add_text($urandom_range(0, 3) == 0 ? CH_STAR : rand_byte());
        add_text(CH_STAR);
        add_text(CH_SLASH);
      end
      6, 7: begin
        add_text(CH_SLASH);
        add_text(rand_byte());
      end
      default: begin
        repeat ($urandom_range(1, 4)) add_text(8'($urandom_range(8'h61, 8'h7A)));
        add_text(CH_SEMI);
        if ($urandom_range(0, 1) == 0) add_text(CH_NL);
      end
    endcase
  endtask

  task automatic drain_results();
    while (pending_res_q.size() != 0) @(negedge clk);
  endtask

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= sink_stall);
  end

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_res_q.size() == 0) begin
        $error("unexpected result transfer: out_byte=%02h run_last=%0b",
               out_tdata, out_tlast);
        err_cnt++;
      end else begin
        head_res = pending_res_q.pop_front();
        if (out_tdata !== head_res.data) begin
          $error("out_byte: expected %02h, got %02h", head_res.data, out_tdata);
          err_cnt++;
        end
        if (out_tlast !== head_res.last) begin
          $error("run_last: expected %0b, got %0b", head_res.last, out_tlast);
          err_cnt++;
        end
      end
    end
  end

  // watchdog: any transfer on either side counts as progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table, no idling on either side
    foreach (dir_tab[i])
      send_byte(dir_tab[i].in_byte, dir_tab[i].n_res, dir_tab[i].res0, dir_tab[i].res1);

    // random text: no idling, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 47; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 47; end
        default: begin src_idle = 18; sink_stall = 18; end
      endcase
      bytes_sent = 0;
      while (bytes_sent < PHASE_ITEMS) begin
        add_construct();
        while (text_q.size() != 0) send_byte(text_q.pop_front(), BY_MODEL, 8'h00, 8'h00);
        // once, mid-phase: hold the sender off until the output side is empty
        if (ph == 2 && !held_off && bytes_sent >= PHASE_ITEMS / 2) begin
          in_tvalid <= 1'b0;
          @(negedge clk);
          drain_results();
          held_off = 1'b1;
        end
      end
    end

    in_tvalid <= 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_res_q.size() != 0) begin
      $error("%0d expected results never arrived", pending_res_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
